// ===== rtl/bba_pkg.sv =====
// Shared types and constants for the bitmap block allocator.
// No dependencies; used by the top level.
`default_nettype none

package bba_pkg;

  localparam int COUNT_W = 11;
  localparam int SIZE_W = 13;
  localparam int ADDR_W = 48;
  localparam int STRIDE_W = SIZE_W + 1;
  localparam int CFG_ADDR_W = 2;
  localparam logic [STRIDE_W-1:0] HEADER_BYTES = STRIDE_W'(8);

  localparam logic [COUNT_W-1:0] RESET_BLOCK_COUNT = COUNT_W'(2047);
  localparam logic [SIZE_W-1:0] RESET_PAYLOAD_BYTES = SIZE_W'(128);

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_BYTES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_ADDRESS = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_RANGE = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/bba_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_block_allocator_top.sv =====
// Bitmap first-fit block allocator: free map in RAM, word summary and count in flops.
// Depends on bba_pkg and bba_ram.
//
//  channel   ports                                  transfer when
//  request   start, busy, action, block_index      start && !busy
//  result    done, status, granted_index,          done (one cycle, no stall)
//            granted_address, free_blocks,
//            zone_full, zone_empty
//  config    cfg_we, cfg_addr, cfg_wdata           cfg_we
//
// A request runs as a RAM read of one map word, a modify and write back,
// then the stride multiply; done is high in the cycle after, when the next
// request may already be taken. The map RAM read port sets the first step.
// Reset and a block_count write mark all words stale at once (per-word valid
// bits), so there is no fill pass. Results cannot be held off.
`default_nettype none

module bitmap_block_allocator_top #(
  parameter int MAX_BLOCKS = 2048,
  parameter int WORD_BITS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              action,
  input  wire logic [bba_pkg::COUNT_W-1:0]       block_index,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [bba_pkg::COUNT_W-1:0]            granted_index,
  output logic [bba_pkg::ADDR_W-1:0]             granted_address,
  output logic [bba_pkg::COUNT_W-1:0]            free_blocks,
  output logic                                   zone_full,
  output logic                                   zone_empty,
  input  wire logic                              cfg_we,
  input  wire logic [bba_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [bba_pkg::ADDR_W-1:0]        cfg_wdata
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int IW = $clog2(MAX_BLOCKS + WORD_BITS) + 1;
  localparam int CW = bba_pkg::COUNT_W;
  localparam int PROD_W = CW + bba_pkg::STRIDE_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOD  = 3'b010,
    S_MUL  = 3'b100
  } state_t;

  // ---------------------------------------------------------------- helpers
  function automatic logic [CW-1:0] cap_count(input logic [CW-1:0] bc);
    logic [CW-1:0] r;
    r = bc;
    if (32'(bc) > 32'(MAX_BLOCKS)) begin
      r = CW'(MAX_BLOCKS);
    end
    return r;
  endfunction

  // Word content after a refill: bits of blocks below the count are set.
  function automatic logic [WORD_BITS-1:0] fill_word(input logic [WADDR_W-1:0] w,
                                                     input logic [CW-1:0] n);
    logic [WORD_BITS-1:0] r;
    logic [IW-1:0] base;
    base = IW'(w) * IW'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      r[b] = (base + IW'(b)) < IW'(n);
    end
    return r;
  endfunction

  function automatic logic [MAP_WORDS-1:0] fill_summary(input logic [CW-1:0] n);
    logic [MAP_WORDS-1:0] r;
    for (int w = 0; w < MAP_WORDS; w++) begin
      r[w] = IW'(w * WORD_BITS) < IW'(n);
    end
    return r;
  endfunction

  function automatic logic [WADDR_W-1:0] lowest_word(input logic [MAP_WORDS-1:0] v);
    logic [WADDR_W-1:0] r;
    r = '0;
    for (int w = MAP_WORDS - 1; w >= 0; w--) begin
      if (v[w]) begin
        r = WADDR_W'(w);
      end
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) begin
        r = BIT_W'(b);
      end
    end
    return r;
  endfunction

  // Word holding a block index: last word whose first block is at or below it.
  function automatic logic [WADDR_W-1:0] word_of(input logic [CW-1:0] idx);
    logic [WADDR_W-1:0] r;
    r = '0;
    for (int w = 0; w < MAP_WORDS; w++) begin
      if (IW'(idx) >= IW'(w * WORD_BITS)) begin
        r = WADDR_W'(w);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- state
  state_t state;
  logic [CW-1:0] block_count;
  logic [bba_pkg::SIZE_W-1:0] payload_bytes;
  logic [bba_pkg::ADDR_W-1:0] base_address;
  logic [MAP_WORDS-1:0] word_valid;
  logic [MAP_WORDS-1:0] summary;
  logic [CW-1:0] free_total;

  logic act_q;
  logic [CW-1:0] idx_q;
  logic [WADDR_W-1:0] word_q;
  logic [BIT_W-1:0] bit_q;

  bba_pkg::status_t st_q;
  logic [CW-1:0] gidx_q;

  logic [PROD_W-1:0] prod;
  logic grant;
  bba_pkg::status_t out_status;
  logic [CW-1:0] out_index;

  logic accept;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] n_new;
  logic [WADDR_W-1:0] rd_word;
  logic [WADDR_W-1:0] acc_word;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] new_word;
  logic [BIT_W-1:0] alloc_bit;
  logic ram_we;
  bba_pkg::status_t st_next;
  logic [bba_pkg::STRIDE_W-1:0] stride;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign n_eff = cap_count(block_count);
  assign n_new = cap_count(cfg_wdata[CW-1:0]);

  assign acc_word = word_of(block_index);
  assign rd_word = (action == bba_pkg::ACT_FREE) ? acc_word : lowest_word(summary);

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_q),
    .wdata (new_word),
    .raddr (rd_word),
    .rdata (ram_rdata)
  );

  // Stale words read as their refill pattern.
  assign cur_word = word_valid[word_q] ? ram_rdata : fill_word(word_q, n_eff);
  assign alloc_bit = lowest_bit(cur_word);

  always_comb begin
    st_next = bba_pkg::ST_OK;
    new_word = cur_word;
    ram_we = 1'b0;
    if (act_q == bba_pkg::ACT_ALLOC) begin
      if (free_total == '0) begin
        st_next = bba_pkg::ST_FULL;
      end else begin
        new_word[alloc_bit] = 1'b0;
        ram_we = (state == S_MOD);
      end
    end else begin
      if (idx_q >= n_eff) begin
        st_next = bba_pkg::ST_RANGE;
      end else if (cur_word[bit_q]) begin
        st_next = bba_pkg::ST_DOUBLE;
      end else begin
        new_word[bit_q] = 1'b1;
        ram_we = (state == S_MOD);
      end
    end
  end

  assign stride = {1'b0, payload_bytes} + bba_pkg::HEADER_BYTES;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      block_count <= bba_pkg::RESET_BLOCK_COUNT;
      payload_bytes <= bba_pkg::RESET_PAYLOAD_BYTES;
      base_address <= '0;
      word_valid <= '0;
      summary <= fill_summary(cap_count(bba_pkg::RESET_BLOCK_COUNT));
      free_total <= cap_count(bba_pkg::RESET_BLOCK_COUNT);
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          bba_pkg::REG_BLOCK_COUNT: begin
            block_count <= cfg_wdata[CW-1:0];
            word_valid <= '0;
            summary <= fill_summary(n_new);
            free_total <= n_new;
          end
          bba_pkg::REG_PAYLOAD_BYTES: payload_bytes <= cfg_wdata[bba_pkg::SIZE_W-1:0];
          bba_pkg::REG_BASE_ADDRESS: base_address <= cfg_wdata;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          state <= S_MUL;
          if (ram_we) begin
            word_valid[word_q] <= 1'b1;
            if (act_q == bba_pkg::ACT_ALLOC) begin
              summary[word_q] <= |new_word;
              free_total <= free_total - CW'(1);
            end else begin
              summary[word_q] <= 1'b1;
              free_total <= free_total + CW'(1);
            end
          end
        end
        S_MUL: begin
          state <= S_IDLE;
          done <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q <= action;
      idx_q <= block_index;
      word_q <= rd_word;
      bit_q <= BIT_W'(IW'(block_index) - IW'(acc_word) * IW'(WORD_BITS));
    end
    if (state == S_MOD) begin
      st_q <= st_next;
      gidx_q <= CW'(IW'(word_q) * IW'(WORD_BITS) + IW'(alloc_bit));
    end
    if (state == S_MUL) begin
      grant <= (act_q == bba_pkg::ACT_ALLOC) && (st_q == bba_pkg::ST_OK);
      out_status <= st_q;
      out_index <= ((act_q == bba_pkg::ACT_ALLOC) && (st_q == bba_pkg::ST_OK)) ?
                   gidx_q : '0;
      prod <= PROD_W'(gidx_q) * PROD_W'(stride);
      free_blocks <= free_total;
      zone_full <= (free_total == '0);
      zone_empty <= (free_total == n_eff);
    end
  end

  assign status = out_status;
  assign granted_index = out_index;
  assign granted_address = grant ? (base_address + bba_pkg::ADDR_W'(prod)) : '0;

  // ---------------------------------------------------------------- checks
  a_done_after_mul: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_MUL))
    else $error("result strobe without a finished request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= n_eff)
    else $error("free count above block count");

  a_summary_total: assert property (@(posedge clk) disable iff (rst)
    (summary == '0) == (free_total == '0))
    else $error("word summary disagrees with free count");

  a_grant_full: assert property (@(posedge clk) disable iff (rst)
    (done && grant) |-> (out_status == bba_pkg::ST_OK))
    else $error("address granted with error status");

endmodule

`default_nettype wire
